FILE: sv/metht_pkg.sv
// ----------------------------------------------------------------------------
// metht_pkg
// Shared types, widths and the CORDIC arctangent table for the MET / HT block.
// ----------------------------------------------------------------------------
`default_nettype none

package metht_pkg;

    // particle kinds
    localparam logic [2:0] KIND_JET      = 3'd2;
    localparam logic [2:0] KIND_BJET     = 3'd3;
    localparam logic [2:0] KIND_NEUTRINO = 3'd4;

    localparam int SUM_W      = 25;   // signed running momentum sums
    localparam int HT_W       = 24;   // scalar HT
    localparam int MAG_W      = 24;   // met_mag output
    localparam int ANG_W      = 16;   // met_angle output
    localparam int CORD_W     = 44;   // CORDIC x/y datapath (sum * 2^16 plus gain)
    localparam int Z_W        = 24;   // angle accumulator, 2^-24 turn units
    localparam int SQ_W       = 50;   // sum of squares
    localparam int ROOT_W     = 25;   // integer square root
    localparam int REM_W      = 28;   // partial remainder incl. two new bits
    localparam int SQRT_STEPS = SQ_W / 2;

    localparam logic [Z_W-1:0] HALF_TURN = 24'h800000;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic [HT_W-1:0]         ht;
        logic                    sat;
    } t_sums;

    typedef struct packed {
        logic                     vld;
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic [Z_W-1:0]           z;
    } t_cord;

    typedef struct packed {
        logic              vld;
        logic [SQ_W-1:0]   s;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] q;
    } t_sqrt;

    // atan(2^-i) in 2^-24 turn
    function automatic logic [Z_W-1:0] atan_val(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = 24'd2097152;
            1:       v = 24'd1238021;
            2:       v = 24'd654136;
            3:       v = 24'd332050;
            4:       v = 24'd166669;
            5:       v = 24'd83416;
            6:       v = 24'd41718;
            7:       v = 24'd20860;
            8:       v = 24'd10430;
            9:       v = 24'd5215;
            10:      v = 24'd2608;
            11:      v = 24'd1304;
            12:      v = 24'd652;
            13:      v = 24'd326;
            14:      v = 24'd163;
            15:      v = 24'd81;
            16:      v = 24'd41;
            17:      v = 24'd20;
            18:      v = 24'd10;
            19:      v = 24'd5;
            20:      v = 24'd3;
            21:      v = 24'd1;
            22:      v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/missing_et_and_ht_sum.sv
// ----------------------------------------------------------------------------
// missing_et_and_ht_sum
// Accumulates -px, -py and jet HT per event; on end of event computes the
// missing ET magnitude (rounded square root) and azimuth (CORDIC) and HT.
// ----------------------------------------------------------------------------
// Throughput: particle items are taken one per cycle, also while a result is
//   being computed. An end-of-event item is stalled while the previous
//   event's result is still in flight or unread (one event at a time).
// Result path: an accepted end-of-event item passes the launch register, the
//   squaring stage, 25 square-root cells and the rounding register to o_valid.
// Reset: synchronous active-low i_rst_n clears sums, counts and all valids.
// ----------------------------------------------------------------------------
`default_nettype none

module missing_et_and_ht_sum #(
    parameter int MAX_PARTICLES = 256,
    parameter int CORDIC_STEPS  = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // particle items
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire                 i_has_particle,
    input  wire  [2:0]          i_kind,
    input  wire  signed [15:0]  i_mom_x,
    input  wire  signed [15:0]  i_mom_y,
    input  wire  [15:0]         i_trans_mom,
    input  wire                 i_end_of_event,
    // result items
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [23:0]         o_met_mag,
    output logic signed [15:0]  o_met_angle,
    output logic [23:0]         o_ht_total,
    output logic                o_saturated
);

    localparam int NSQ = metht_pkg::SQRT_STEPS;

    // handshake
    logic w_in_acc;
    logic w_launch;
    logic w_out_acc;
    logic r_busy;

    assign o_stall   = r_busy && i_end_of_event;
    assign w_in_acc  = i_valid && !o_stall;
    assign w_launch  = w_in_acc && i_end_of_event;
    assign w_out_acc = o_valid && !i_stall;

    // ------------------------------------------------------------------
    // event accumulator
    // ------------------------------------------------------------------
    metht_pkg::t_sums w_final;

    metht_accum #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_in_acc),
        .i_has_particle (i_has_particle),
        .i_kind         (i_kind),
        .i_mom_x        (i_mom_x),
        .i_mom_y        (i_mom_y),
        .i_trans_mom    (i_trans_mom),
        .i_end_of_event (i_end_of_event),
        .o_final        (w_final)
    );

    // ------------------------------------------------------------------
    // launch register: final event sums, held until the result is taken
    // ------------------------------------------------------------------
    metht_pkg::t_sums r_ev;
    logic             r_ev_vld;
    logic             r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_vld <= 1'b0;
        end else begin
            r_ev_vld <= w_launch;
        end
        if (w_launch) begin
            r_ev   <= w_final;
            r_zero <= (w_final.sx == '0) && (w_final.sy == '0);
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chain: scale by 2^16, fold into the right half plane first
    // ------------------------------------------------------------------
    metht_pkg::t_cord w_cord [0:CORDIC_STEPS];
    logic signed [metht_pkg::CORD_W-1:0] w_x0;
    logic signed [metht_pkg::CORD_W-1:0] w_y0;

    always_comb begin
        w_x0 = {{(metht_pkg::CORD_W-metht_pkg::SUM_W-16){r_ev.sx[metht_pkg::SUM_W-1]}},
                r_ev.sx, 16'h0000};
        w_y0 = {{(metht_pkg::CORD_W-metht_pkg::SUM_W-16){r_ev.sy[metht_pkg::SUM_W-1]}},
                r_ev.sy, 16'h0000};
        w_cord[0].vld = r_ev_vld;
        if (r_ev.sx[metht_pkg::SUM_W-1]) begin
            w_cord[0].x = -w_x0;
            w_cord[0].y = -w_y0;
            w_cord[0].z = metht_pkg::HALF_TURN;
        end else begin
            w_cord[0].x = w_x0;
            w_cord[0].y = w_y0;
            w_cord[0].z = '0;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cord
        metht_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cord  (w_cord[g]),
            .o_cord  (w_cord[g+1])
        );
    end

    // angle = round(z / 256) mod 2^16; zero vector gives zero
    logic [metht_pkg::Z_W:0]         w_zr;
    logic signed [metht_pkg::ANG_W-1:0] r_angle;

    assign w_zr = {1'b0, w_cord[CORDIC_STEPS].z} + (metht_pkg::Z_W+1)'(128);

    always_ff @(posedge i_clk) begin
        if (w_cord[CORDIC_STEPS].vld) begin
            r_angle <= r_zero ? '0 : w_zr[metht_pkg::Z_W-1:8];
        end
    end

    // ------------------------------------------------------------------
    // squaring stage, then the square-root chain
    // ------------------------------------------------------------------
    logic signed [2*metht_pkg::SUM_W-1:0] r_sqx;
    logic signed [2*metht_pkg::SUM_W-1:0] r_sqy;
    logic                                 r_sq_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else begin
            r_sq_vld <= r_ev_vld;
        end
        r_sqx <= r_ev.sx * r_ev.sx;
        r_sqy <= r_ev.sy * r_ev.sy;
    end

    metht_pkg::t_sqrt w_sq [0:NSQ];
    logic [NSQ-1:0]   w_sq_vld;

    always_comb begin
        w_sq[0].vld = r_sq_vld;
        w_sq[0].s   = metht_pkg::SQ_W'(r_sqx) + metht_pkg::SQ_W'(r_sqy);
        w_sq[0].rem = '0;
        w_sq[0].q   = '0;
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        metht_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sq    (w_sq[k]),
            .o_sq    (w_sq[k+1])
        );
        assign w_sq_vld[k] = w_sq[k+1].vld;
    end

    // round to nearest: bump when remainder exceeds the root
    logic [metht_pkg::ROOT_W-1:0] w_root;
    logic [metht_pkg::MAG_W-1:0]  r_mag;
    logic                         r_out_vld;

    assign w_root = (w_sq[NSQ].rem > metht_pkg::REM_W'(w_sq[NSQ].q))
                  ? w_sq[NSQ].q + metht_pkg::ROOT_W'(1) : w_sq[NSQ].q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_busy    <= 1'b0;
        end else begin
            if (w_sq[NSQ].vld) begin
                r_out_vld <= 1'b1;
            end else if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
            if (w_launch) begin
                r_busy <= 1'b1;
            end else if (w_out_acc) begin
                r_busy <= 1'b0;
            end
        end
        if (w_sq[NSQ].vld) begin
            r_mag <= w_root[metht_pkg::MAG_W-1:0];
        end
    end

    assign o_valid     = r_out_vld;
    assign o_met_mag   = r_mag;
    assign o_met_angle = r_angle;
    assign o_ht_total  = r_ev.ht;
    assign o_saturated = r_ev.sat;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_out_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_busy)
        else $error("result valid outside a busy window");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_sq_vld) <= 1)
        else $error("more than one event in the sqrt chain");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq[NSQ].vld |-> !r_out_vld)
        else $error("new magnitude while result still pending");

    a_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_launch |=> r_busy && r_ev_vld)
        else $error("launch did not start the engine");

    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |=> !o_valid)
        else $error("result repeated after being taken");

endmodule

`default_nettype wire

FILE: sv/metht_accum.sv
// ----------------------------------------------------------------------------
// metht_accum
// Per-event running sums of -px, -py, jet HT and the particle count.
// ----------------------------------------------------------------------------
`default_nettype none

module metht_accum #(
    parameter int MAX_PARTICLES = 256
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_accept,
    input  wire                         i_has_particle,
    input  wire  [2:0]                  i_kind,
    input  wire  signed [15:0]          i_mom_x,
    input  wire  signed [15:0]          i_mom_y,
    input  wire  [15:0]                 i_trans_mom,
    input  wire                         i_end_of_event,
    output metht_pkg::t_sums            o_final
);

    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

    metht_pkg::t_sums r_sums;
    logic [CNT_W-1:0] r_cnt;
    metht_pkg::t_sums n_sums;
    logic [CNT_W-1:0] n_cnt;
    logic             w_full;
    logic             w_take;

    // Sums cannot leave their ranges for up to 256 particles, so no clamp.
    always_comb begin
        w_full = (r_cnt == CNT_MAX);
        w_take = i_has_particle && !w_full;
        n_sums = r_sums;
        n_cnt  = r_cnt;
        if (i_has_particle && w_full) begin
            n_sums.sat = 1'b1;
        end
        if (w_take) begin
            n_cnt = r_cnt + CNT_W'(1);
            if (i_kind != metht_pkg::KIND_NEUTRINO) begin
                n_sums.sx = r_sums.sx - metht_pkg::SUM_W'(i_mom_x);
                n_sums.sy = r_sums.sy - metht_pkg::SUM_W'(i_mom_y);
            end
            if (i_kind == metht_pkg::KIND_JET || i_kind == metht_pkg::KIND_BJET) begin
                n_sums.ht = r_sums.ht + metht_pkg::HT_W'(i_trans_mom);
            end
        end
    end

    assign o_final = n_sums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
            r_cnt  <= '0;
        end else if (i_accept) begin
            if (i_end_of_event) begin
                r_sums <= '0;
                r_cnt  <= '0;
            end else begin
                r_sums <= n_sums;
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/metht_cordic_cell.sv
// ----------------------------------------------------------------------------
// metht_cordic_cell
// One registered CORDIC vectoring step; the step index sets shift and angle.
// ----------------------------------------------------------------------------
`default_nettype none

module metht_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  metht_pkg::t_cord    i_cord,
    output metht_pkg::t_cord    o_cord
);

    localparam logic [metht_pkg::Z_W-1:0] ATAN = metht_pkg::atan_val(STEP);

    metht_pkg::t_cord r_cord;
    metht_pkg::t_cord n_cord;
    logic signed [metht_pkg::CORD_W-1:0] w_xs;
    logic signed [metht_pkg::CORD_W-1:0] w_ys;
    logic w_pos;

    always_comb begin
        w_xs  = i_cord.x >>> STEP;   // arithmetic shift = floor shift
        w_ys  = i_cord.y >>> STEP;
        w_pos = !i_cord.y[metht_pkg::CORD_W-1] && (i_cord.y != '0);
        n_cord.vld = i_cord.vld;
        if (w_pos) begin
            n_cord.x = i_cord.x + w_ys;
            n_cord.y = i_cord.y - w_xs;
            n_cord.z = i_cord.z + ATAN;
        end else begin
            n_cord.x = i_cord.x - w_ys;
            n_cord.y = i_cord.y + w_xs;
            n_cord.z = i_cord.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cord.vld <= 1'b0;
        end else begin
            r_cord.vld <= n_cord.vld;
        end
        r_cord.x <= n_cord.x;
        r_cord.y <= n_cord.y;
        r_cord.z <= n_cord.z;
    end

    assign o_cord = r_cord;

endmodule

`default_nettype wire

FILE: sv/metht_sqrt_cell.sv
// ----------------------------------------------------------------------------
// metht_sqrt_cell
// One registered digit of the bit-pair integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module metht_sqrt_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  metht_pkg::t_sqrt    i_sq,
    output metht_pkg::t_sqrt    o_sq
);

    metht_pkg::t_sqrt r_sq;
    metht_pkg::t_sqrt n_sq;
    logic [metht_pkg::REM_W-1:0] w_rem;
    logic [metht_pkg::REM_W-1:0] w_trial;

    // remainder stays below 2^26, so dropping its top two bits loses nothing
    always_comb begin
        w_rem   = {i_sq.rem[metht_pkg::REM_W-3:0], i_sq.s[metht_pkg::SQ_W-1 -: 2]};
        w_trial = {1'b0, i_sq.q, 2'b01};
        n_sq.vld = i_sq.vld;
        n_sq.s   = {i_sq.s[metht_pkg::SQ_W-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_sq.rem = w_rem - w_trial;
            n_sq.q   = {i_sq.q[metht_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_sq.rem = w_rem;
            n_sq.q   = {i_sq.q[metht_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.vld <= 1'b0;
        end else begin
            r_sq.vld <= n_sq.vld;
        end
        r_sq.s   <= n_sq.s;
        r_sq.rem <= n_sq.rem;
        r_sq.q   <= n_sq.q;
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire
